FILE: sv/vvp_pkg.sv
// Vertex view projection: shared constants, types and register indexes.
// No dependencies.
package vvp_pkg;

    localparam int NUM_W = 52;   // dividend magnitude width
    localparam int DEN_W = 36;   // divisor width (view z)

    localparam logic signed [35:0] NEAR_Z    = 36'sd80;
    localparam logic signed [46:0] VIS_LIMIT = 47'sd5000;
    localparam logic signed [53:0] ROW_BASE  = 54'sd199;
    localparam logic signed [46:0] OUT_MIN   = -47'sd8192;
    localparam logic signed [46:0] OUT_MAX   = 47'sd8191;

    typedef enum logic [2:0] {
        CFG_CAM_X   = 3'd0,
        CFG_CAM_Y   = 3'd1,
        CFG_CAM_Z   = 3'd2,
        CFG_VIEW_D  = 3'd3,
        CFG_CTR_X   = 3'd4,
        CFG_CTR_Y   = 3'd5,
        CFG_SCALE   = 3'd6,
        CFG_UNUSED  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic clip;
    } t_side;

endpackage

FILE: sv/vertex_view_projection_unit.sv
// Vertex view projection: top level, camera transform, perspective and screen mapping.
// Depends on vvp_pkg and vvp_div.
//
//  channel   dir  item
//  s_axis    in   one vertex and its nine view coefficients
//  m_axis    out  screen position and clip/visibility flags
//  cfg       in   register write, no read-back
//
// One item per cycle while the output is not stalled; the 52-stage divider makes up most of the pipeline.
// Synchronous active-low reset clears valid bits and loads register defaults.
// The whole pipeline holds while the output item waits; nothing is lost or repeated.
module vertex_view_projection_unit
    import vvp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // world_x, world_y, world_z, view_x_from_x, view_y_from_x, view_z_from_x,
    // view_x_from_y, view_y_from_y, view_z_from_y, view_x_from_z, view_y_from_z,
    // view_z_from_z
    input  logic [239:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // screen_x, screen_y, zero pad
    output logic [31:0]  m_axis_tdata,
    // near_clipped, visible
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata
);

    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic        [15:0] r_view_d;
    logic signed [15:0] r_ctr_x, r_ctr_y;
    logic        [7:0]  r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x  <= '0;
            r_cam_y  <= '0;
            r_cam_z  <= '0;
            r_view_d <= 16'd1024;
            r_ctr_x  <= '0;
            r_ctr_y  <= '0;
            r_scale  <= 8'd64;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CAM_X:  r_cam_x  <= i_cfg_wdata;
                CFG_CAM_Y:  r_cam_y  <= i_cfg_wdata;
                CFG_CAM_Z:  r_cam_z  <= i_cfg_wdata;
                CFG_VIEW_D: r_view_d <= i_cfg_wdata[15:0];
                CFG_CTR_X:  r_ctr_x  <= i_cfg_wdata[15:0];
                CFG_CTR_Y:  r_ctr_y  <= i_cfg_wdata[15:0];
                CFG_SCALE:  r_scale  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    logic r_ov;
    logic en;
    assign en            = !r_ov || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: camera-relative position
    logic               r1_v;
    logic signed [32:0] r1_d [0:2];
    logic signed [15:0] r1_k [0:8];
    logic signed [31:0] wx, wy, wz;
    assign wx = s_axis_tdata[31:0];
    assign wy = s_axis_tdata[63:32];
    assign wz = s_axis_tdata[95:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0] <= {wx[31], wx} - {r_cam_x[31], r_cam_x};
            r1_d[1] <= {wy[31], wy} - {r_cam_y[31], r_cam_y};
            r1_d[2] <= {wz[31], wz[31], wz[31:1]} - {r_cam_z[31], r_cam_z};
        end
    end
    for (genvar i = 0; i < 9; i++) begin : g_k
        always_ff @(posedge i_clk) begin
            if (en) r1_k[i] <= s_axis_tdata[96+16*i +: 16];
        end
    end

    // stage 2: nine products
    logic               r2_v;
    logic signed [48:0] r2_p [0:8];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    for (genvar i = 0; i < 9; i++) begin : g_mul
        always_ff @(posedge i_clk) begin
            if (en) r2_p[i] <= r1_d[i/3] * r1_k[i];
        end
    end

    // stage 3: view coordinates, near clip
    logic               r3_v, r3_clip;
    logic signed [35:0] r3_vx, r3_vy, r3_vz;
    logic signed [50:0] sum [0:2];
    logic signed [35:0] vzc;
    for (genvar t = 0; t < 3; t++) begin : g_sum
        assign sum[t] = 51'(r2_p[t]) + 51'(r2_p[3+t]) + 51'(r2_p[6+t]);
    end
    assign vzc = sum[2][49:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_vx   <= sum[0][49:14];
            r3_vy   <= sum[1][49:14];
            r3_clip <= vzc < NEAR_Z;
            r3_vz   <= (vzc < NEAR_Z) ? NEAR_Z : vzc;
        end
    end

    // stage 4: partial products of the numerators
    logic               r4_v, r4_clip;
    logic        [35:0] r4_vz;
    logic        [33:0] r4_xl, r4_yl;
    logic signed [34:0] r4_xh, r4_yh, r4_cxl, r4_cxh, r4_cyl, r4_cyh;
    logic signed [16:0] vd;
    logic signed [18:0] zl, zh;
    assign vd = {1'b0, r_view_d};
    assign zl = {1'b0, r3_vz[17:0]};
    assign zh = {1'b0, r3_vz[35:18]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_xl   <= r_view_d * r3_vx[17:0];
            r4_yl   <= r_view_d * r3_vy[17:0];
            r4_xh   <= vd * $signed(r3_vx[35:18]);
            r4_yh   <= vd * $signed(r3_vy[35:18]);
            r4_cxl  <= r_ctr_x * zl;
            r4_cxh  <= r_ctr_x * zh;
            r4_cyl  <= r_ctr_y * zl;
            r4_cyh  <= r_ctr_y * zh;
            r4_vz   <= r3_vz;
            r4_clip <= r3_clip;
        end
    end

    // stage 5: numerator sum and magnitude
    logic signed [53:0] nx, ny, ax, ay;
    assign nx = (54'(r4_xh) <<< 18) + 54'($signed({1'b0, r4_xl}))
              + (54'(r4_cxh) <<< 18) + 54'(r4_cxl);
    assign ny = (54'(r4_yh) <<< 18) + 54'($signed({1'b0, r4_yl}))
              + (54'(r4_cyh) <<< 18) + 54'(r4_cyl);
    assign ax = nx[53] ? -nx : nx;
    assign ay = ny[53] ? -ny : ny;

    logic [NUM_W-1:0] r5_mx, r5_my;
    logic [DEN_W-1:0] r5_vz;
    logic             r5_v;
    t_side            r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_mx         <= ax[NUM_W-1:0];
            r5_my         <= ay[NUM_W-1:0];
            r5_vz         <= r4_vz;
            r5_side.neg_x <= nx[53];
            r5_side.neg_y <= ny[53];
            r5_side.clip  <= r4_clip;
        end
    end

    // divide stages
    logic [NUM_W-1:0] qx, qy;
    vvp_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r5_mx), .i_den(r5_vz), .o_quo(qx));
    vvp_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r5_my), .i_den(r5_vz), .o_quo(qy));

    logic [NUM_W-1:0] r_side_v;
    t_side            r_side [0:NUM_W-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_side_v <= '0;
        else if (en) r_side_v <= {r_side_v[NUM_W-2:0], r5_v};
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= r5_side;
            for (int j = 1; j < NUM_W; j++) r_side[j] <= r_side[j-1];
        end
    end
    t_side sd;
    assign sd = r_side[NUM_W-1];

    // stage 7: signed quotients
    logic               r7_v, r7_clip;
    logic signed [52:0] r7_px, r7_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r_side_v[NUM_W-1];
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_px   <= sd.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            r7_py   <= sd.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            r7_clip <= sd.clip;
        end
    end

    // stage 8: x shift, row flip with clamp
    logic               r8_v, r8_clip;
    logic signed [46:0] r8_sx;
    logic signed [21:0] r8_d;
    logic signed [53:0] dy;
    assign dy = ROW_BASE - 54'(r7_py);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= r7_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_sx   <= r7_px[52:6];
            r8_clip <= r7_clip;
            if (dy > 54'sd2097151)       r8_d <= 22'sd2097151;
            else if (dy < -54'sd2097152) r8_d <= -22'sd2097152;
            else                         r8_d <= dy[21:0];
        end
    end

    // stage 9: row scale, visibility, saturation
    logic signed [30:0] yp;
    logic signed [46:0] sy;
    logic               vis;
    assign yp  = $signed({1'b0, r_scale}) * r8_d;
    assign sy  = 47'($signed(yp[30:6]));
    assign vis = !r8_clip && (r8_sx >= -VIS_LIMIT) && (r8_sx <= VIS_LIMIT)
                 && (sy >= -VIS_LIMIT) && (sy <= VIS_LIMIT);

    logic [13:0] r_sx, r_sy;
    logic        r_clip, r_vis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= r8_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx   <= (r8_sx < OUT_MIN) ? OUT_MIN[13:0] :
                      (r8_sx > OUT_MAX) ? OUT_MAX[13:0] : r8_sx[13:0];
            r_sy   <= (sy < OUT_MIN) ? OUT_MIN[13:0] :
                      (sy > OUT_MAX) ? OUT_MAX[13:0] : sy[13:0];
            r_clip <= r8_clip;
            r_vis  <= vis;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'd0, r_sy, r_sx};
    assign m_axis_tuser  = {r_vis, r_clip};

endmodule

FILE: sv/vvp_div.sv
// Vertex view projection: pipelined restoring divider, one quotient bit a stage.
// Depends on vvp_pkg.
module vvp_div
    import vvp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] w_n [0:NUM_W];
    logic [DEN_W-1:0] w_r [0:NUM_W-1];
    logic [DEN_W-1:0] w_d [0:NUM_W-1];

    assign w_n[0] = i_num;
    assign w_r[0] = '0;
    assign w_d[0] = i_den;

    for (genvar j = 0; j < NUM_W; j++) begin : g_stage
        logic [DEN_W:0]   t;
        logic             ge;
        logic [DEN_W-1:0] diff;
        logic [NUM_W-1:0] r_n;

        always_comb begin
            t    = {w_r[j], w_n[j][NUM_W-1]};
            ge   = (t >= {1'b0, w_d[j]});
            diff = t[DEN_W-1:0] - w_d[j];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n <= {w_n[j][NUM_W-2:0], ge};
            end
        end

        assign w_n[j+1] = r_n;

        if (j < NUM_W-1) begin : g_rem
            logic [DEN_W-1:0] r_r;
            logic [DEN_W-1:0] r_d;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r <= ge ? diff : t[DEN_W-1:0];
                    r_d <= w_d[j];
                end
            end

            assign w_r[j+1] = r_r;
            assign w_d[j+1] = r_d;
        end
    end

    assign o_quo = w_n[NUM_W];

endmodule
